// ----- rtl/lss_pkg.sv -----
// Shared package of the log-spaced sweep generator.
// Holds widths, register indexes, command/status structs and the root-table functions.
// No dependencies.
`default_nettype none

package lss_pkg;

  localparam int EXP_REG_BITS = 23;
  localparam int ACC_BITS = 24;
  localparam int MAG_BITS = 23;
  localparam int POW_STEPS = 20;
  localparam int MANT_BITS = 16;
  localparam int BEXP_BITS = 8;
  localparam int INDEX_BITS = 16;
  localparam int ITER_BITS = 5;
  localparam int PROD_BITS = ACC_BITS + 33;
  localparam int DEF_FRACTION_BITS = 16;
  localparam int DEF_COUNT_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [31:0] LOG2_10_Q30 = 32'd3566893132;

  localparam logic [CFG_INDEX_BITS-1:0] REG_START = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_END = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT = 2'd2;

  localparam logic [ITER_BITS-1:0] DIV_LAST = ITER_BITS'(MAG_BITS - 1);
  localparam logic [ITER_BITS-1:0] POW_LAST = ITER_BITS'(POW_STEPS - 1);

  typedef struct packed {
    logic                 load_div;
    logic                 div_step;
    logic                 set_sweep;
    logic                 eval;
    logic                 mul;
    logic                 pow_step;
    logic                 finish;
    logic [ITER_BITS-1:0] iter;
  } lss_cmd_t;

  typedef struct packed {
    logic active;
    logic out_busy;
  } lss_stat_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] rem;
    res = '0;
    bt = 64'd1 << 62;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (bt > rem) begin
        bt = bt >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (bt != 64'd0) begin
        if (rem >= res + bt) begin
          rem = rem - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  // 2^(2^-k) in Q1.31, built by repeated floor square roots.
  function automatic logic [31:0] pow_root(int k);
    logic [63:0] r;
    r = isqrt64(64'd1 << 63);
    for (int i = 1; i < POW_STEPS; i++) begin
      if (i < k) begin
        r = isqrt64(r << 31);
      end
    end
    return r[31:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/log_spaced_sweep_generator.sv -----
// A restart beat runs the step divider, loads the sweep, evaluates, multiplies and takes the
// root steps before its result; a next-element beat starts at the evaluation, then runs the
// 20-step serial root multiplier. One beat is in work at a time; a new beat is taken only
// once the last result has entered the output register, which waits while that is stalled.
// Synchronous active-high reset restores config and control defaults and stops any sweep.
// Top level of the log-spaced sweep generator; uses lss_pkg, lss_ctrl and lss_dp.
`default_nettype none

module log_spaced_sweep_generator
  import lss_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int CFG_BITS = (COUNT_BITS > EXP_REG_BITS) ? COUNT_BITS : EXP_REG_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_data,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [7:0]                s_tdata,  // restart
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [39:0]                    m_tdata,  // mantissa, binary_exponent, element_index
  output logic                           m_tlast
);

  lss_cmd_t              cmd;
  lss_stat_t             stat;
  logic [MANT_BITS-1:0]  mantissa;
  logic [BEXP_BITS-1:0]  bexp;
  logic [INDEX_BITS-1:0] index;

  assign cfg_ready = 1'b1;
  assign m_tdata = {index, bexp, mantissa};

  lss_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_restart (s_tdata[0]),
    .in_ready   (s_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lss_dp #(
    .FRACTION_BITS (FRACTION_BITS),
    .COUNT_BITS    (COUNT_BITS),
    .CFG_BITS      (CFG_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_mantissa (mantissa),
    .out_bexp     (bexp),
    .out_index    (index),
    .out_last     (m_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/lss_ctrl.sv -----
// Controller of the log-spaced sweep generator.
// Sequences division, evaluation, multiply and root steps; uses lss_pkg.
`default_nettype none

module lss_ctrl
  import lss_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_restart,
  output logic           in_ready,
  input  wire lss_stat_t stat,
  output lss_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV = 3'd1;
  localparam logic [2:0] S_SET = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_MUL = 3'd4;
  localparam logic [2:0] S_POW = 3'd5;
  localparam logic [2:0] S_FIN = 3'd6;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [ITER_BITS-1:0] iter;
  logic [ITER_BITS-1:0] iter_next;
  logic                 accept;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    iter_next = iter;
    cmd = '0;
    cmd.iter = iter;
    unique case (state)
      S_IDLE: begin
        iter_next = '0;
        if (accept) begin
          if (in_restart) begin
            cmd.load_div = 1'b1;
            state_next = S_DIV;
          end else if (stat.active) begin
            cmd.eval = 1'b1;
            state_next = S_MUL;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        iter_next = iter + 1'b1;
        if (iter == DIV_LAST) begin
          state_next = S_SET;
        end
      end
      S_SET: begin
        cmd.set_sweep = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        iter_next = '0;
        state_next = S_POW;
      end
      S_POW: begin
        cmd.pow_step = 1'b1;
        iter_next = iter + 1'b1;
        if (iter == POW_LAST) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter <= '0;
    end else begin
      state <= state_next;
      iter <= iter_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lss_dp.sv -----
// Datapath of the log-spaced sweep generator.
// Registers, step divider, accumulator, 10^y evaluation and output stage; uses lss_pkg.
`default_nettype none

module lss_dp
  import lss_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int CFG_BITS = EXP_REG_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_data,
  input  wire lss_cmd_t                  cmd,
  output lss_stat_t                      stat,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [MANT_BITS-1:0]           out_mantissa,
  output logic [BEXP_BITS-1:0]           out_bexp,
  output logic [INDEX_BITS-1:0]          out_index,
  output logic                           out_last
);

  localparam int F = FRACTION_BITS + 30;

  logic [EXP_REG_BITS-1:0]   start_exp;
  logic [EXP_REG_BITS-1:0]   end_exp;
  logic [COUNT_BITS-1:0]     count;
  logic signed [ACC_BITS-1:0] acc;
  logic [ACC_BITS-1:0]       step;
  logic [COUNT_BITS-1:0]     position;
  logic                      active;

  logic [COUNT_BITS:0]       div_rem;
  logic [MAG_BITS-1:0]       div_q;
  logic [COUNT_BITS-1:0]     div_n;
  logic                      div_neg;

  logic signed [ACC_BITS-1:0]  y_q;
  logic                        last_q;
  logic [INDEX_BITS-1:0]       index_q;
  logic signed [PROD_BITS-1:0] prod;
  logic [31:0]                 m;

  logic [31:0] root_tab [POW_STEPS];

  logic [COUNT_BITS-1:0]      cnt_eff;
  logic signed [ACC_BITS-1:0] start_sx;
  logic signed [ACC_BITS-1:0] end_sx;
  logic signed [ACC_BITS-1:0] diff;
  logic [COUNT_BITS:0]        trial;
  logic                       is_last;
  logic [POW_STEPS-1:0]       xfrac;
  logic [63:0]                mr;
  logic [32:0]                rnd;
  logic signed [PROD_BITS-1:0] e_adj;
  logic [ACC_BITS-1:0]        qext;

  for (genvar g = 0; g < POW_STEPS; g++) begin : g_root
    assign root_tab[g] = pow_root(g + 1);
  end

  assign cnt_eff = (count == '0) ? COUNT_BITS'(1) : count;
  assign start_sx = {start_exp[EXP_REG_BITS-1], start_exp};
  assign end_sx = {end_exp[EXP_REG_BITS-1], end_exp};
  assign diff = end_sx - start_sx;
  assign trial = {div_rem[COUNT_BITS-1:0], div_q[MAG_BITS-1]};
  assign is_last = ({1'b0, position} + 1'b1) >= {1'b0, cnt_eff};
  assign xfrac = prod[F-1 -: POW_STEPS];
  assign mr = {32'd0, m} * {32'd0, root_tab[cmd.iter]};
  assign rnd = {1'b0, m} + 33'd32768;
  assign e_adj = (prod >>> F) + $signed(PROD_BITS'(rnd[32]));
  assign qext = ACC_BITS'(div_q);

  assign stat.active = active;
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_exp <= '0;
      end_exp <= EXP_REG_BITS'(65536);
      count <= COUNT_BITS'(2);
      active <= 1'b0;
      acc <= '0;
      step <= '0;
      position <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_START: start_exp <= cfg_data[EXP_REG_BITS-1:0];
          REG_END:   end_exp <= cfg_data[EXP_REG_BITS-1:0];
          REG_COUNT: count <= cfg_data[COUNT_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.set_sweep) begin
        if (div_n == '0) begin
          step <= '0;
        end else if (div_neg) begin
          step <= -qext;
        end else begin
          step <= qext;
        end
        acc <= start_sx;
        position <= '0;
        active <= 1'b1;
      end
      if (cmd.eval) begin
        if (is_last) begin
          active <= 1'b0;
        end else begin
          position <= position + 1'b1;
          acc <= acc + $signed(step);
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      div_neg <= diff[ACC_BITS-1];
      div_q <= diff[ACC_BITS-1] ? MAG_BITS'(-diff) : MAG_BITS'(diff);
      div_rem <= '0;
      div_n <= cnt_eff - 1'b1;
    end
    if (cmd.div_step) begin
      if (trial >= {1'b0, div_n}) begin
        div_rem <= trial - {1'b0, div_n};
        div_q <= {div_q[MAG_BITS-2:0], 1'b1};
      end else begin
        div_rem <= trial;
        div_q <= {div_q[MAG_BITS-2:0], 1'b0};
      end
    end
    if (cmd.eval) begin
      y_q <= is_last ? end_sx : acc;
      last_q <= is_last;
      index_q <= INDEX_BITS'(position);
    end
    if (cmd.mul) begin
      prod <= y_q * $signed({1'b0, LOG2_10_Q30});
      m <= 32'h8000_0000;
    end
    if (cmd.pow_step && xfrac[POW_STEPS-1-int'(cmd.iter)]) begin
      m <= mr[62:31];
    end
    if (cmd.finish) begin
      out_last <= last_q;
      out_index <= index_q;
      if (e_adj > PROD_BITS'(126)) begin
        out_mantissa <= 16'hFFFF;
        out_bexp <= 8'sd126;
      end else if (e_adj < -PROD_BITS'(127)) begin
        out_mantissa <= 16'h8000;
        out_bexp <= -8'sd127;
      end else begin
        out_mantissa <= rnd[32] ? 16'h8000 : rnd[31:16];
        out_bexp <= e_adj[BEXP_BITS-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lss_checker.sv -----
// Port-level checker of the log-spaced sweep generator, bound to the top level.
// Depends on log_spaced_sweep_generator only through its ports.
`default_nettype none

module lss_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_restart_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[0] |=> !s_tready)
    else $error("restart beat did not occupy the block");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while the block was idle");

endmodule

bind log_spaced_sweep_generator lss_checker u_lss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
